// ===== rtl/slxfp_pkg.sv =====
`default_nettype none

package slxfp_pkg;

  localparam int unsigned FRAME_BUF_LEN = 256;

  localparam int unsigned PosW = 9;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam logic [PosW-1:0] POS_HUNT   = PosW'(0);
  localparam logic [PosW-1:0] POS_SYNC2  = PosW'(1);
  localparam logic [PosW-1:0] POS_LENGTH = PosW'(2);
  localparam logic [PosW-1:0] POS_CMD    = PosW'(3);

  localparam logic [PosW-1:0] BUF_LIMIT = PosW'(FRAME_BUF_LEN);

  typedef struct packed {
    logic [7:0]      echo_byte;
    logic [PosW-1:0] position;
    logic            in_frame;
    logic            frame_end;
    logic            frame_ok;
    logic            frame_abort;
    logic [7:0]      command;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/slxfp_core.sv =====
`default_nettype none

module slxfp_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output slxfp_pkg::result_t    res_o
);

  logic [slxfp_pkg::PosW-1:0] idx_q, idx_d;
  logic [7:0]                 len_q, len_d;
  logic [7:0]                 xor_q, xor_d;
  logic [7:0]                 cmd_q, cmd_d;

  logic [7:0]                 len_eff;
  logic [7:0]                 xor_eff;
  logic [7:0]                 cmd_eff;
  logic [slxfp_pkg::PosW-1:0] end_pos;

  // length, xor and command as seen by the current word (taken live at their positions)
  always_comb begin
    len_eff = (idx_q == slxfp_pkg::POS_LENGTH) ? byte_i : len_q;
    xor_eff = (idx_q == slxfp_pkg::POS_LENGTH) ? 8'h00 : xor_q;
    cmd_eff = (idx_q == slxfp_pkg::POS_CMD) ? byte_i : cmd_q;
    end_pos = {1'b0, len_eff} + slxfp_pkg::POS_CMD;
  end

  always_comb begin
    idx_d = idx_q;
    len_d = len_q;
    xor_d = xor_q;
    cmd_d = cmd_q;

    res_o             = '0;
    res_o.echo_byte   = byte_i;
    res_o.position    = idx_q;

    if (idx_q == slxfp_pkg::POS_HUNT) begin
      if (byte_i == slxfp_pkg::SYNC_FIRST) begin
        res_o.in_frame = 1'b1;
        idx_d          = slxfp_pkg::POS_SYNC2;
      end
    end else if (idx_q == slxfp_pkg::POS_SYNC2) begin
      if (byte_i == slxfp_pkg::SYNC_SECOND) begin
        res_o.in_frame = 1'b1;
        idx_d          = slxfp_pkg::POS_LENGTH;
      end else if (byte_i == slxfp_pkg::SYNC_FIRST) begin
        res_o.in_frame = 1'b1;
      end else begin
        idx_d = slxfp_pkg::POS_HUNT;
      end
    end else begin
      len_d = len_eff;
      xor_d = xor_eff;
      cmd_d = cmd_eff;
      if (idx_q == end_pos) begin
        res_o.in_frame  = 1'b1;
        res_o.frame_end = 1'b1;
        res_o.frame_ok  = (xor_eff == byte_i);
        res_o.command   = cmd_eff;
        idx_d           = slxfp_pkg::POS_HUNT;
      end else if (idx_q >= slxfp_pkg::BUF_LIMIT) begin
        res_o.frame_abort = 1'b1;
        idx_d             = slxfp_pkg::POS_HUNT;
      end else begin
        res_o.in_frame = 1'b1;
        xor_d          = xor_eff ^ byte_i;
        idx_d          = idx_q + slxfp_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= slxfp_pkg::POS_HUNT;
      len_q <= '0;
      xor_q <= '0;
      cmd_q <= '0;
    end else if (step_i) begin
      idx_q <= idx_d;
      len_q <= len_d;
      xor_q <= xor_d;
      cmd_q <= cmd_d;
    end
  end

  a_idx_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= slxfp_pkg::BUF_LIMIT)
    else $error("frame position beyond buffer limit");

  a_end_rehunt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res_o.frame_end || res_o.frame_abort) |=> idx_q == slxfp_pkg::POS_HUNT)
    else $error("hunt not restarted after frame end or abort");

  a_abort_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.frame_abort |-> !res_o.in_frame && !res_o.frame_end)
    else $error("aborted word flagged as in frame");

  a_end_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.frame_end |-> !res_o.frame_ok && res_o.command == 8'h00)
    else $error("ok or command set outside frame end");

endmodule

`default_nettype wire

// ===== rtl/sync_length_xor_frame_parser.sv =====
// Byte-stream deframer for frames of 0xAA 0x55 L, then L+1 bytes ending in an XOR
// checksum over the length byte and payload. Every accepted byte gives exactly one
// result word: the byte, its frame position, in-frame/end/abort flags, and at frame
// end the checksum verdict and the command byte (position 3). One byte per cycle is
// sustained while results are taken; a byte's result is registered in the result
// register after the byte passes from the input register through the combinational
// parse step. A stalled result holds the input register, so at most two bytes wait
// inside. Frames whose position reaches FRAME_BUF_LEN before their end are aborted.
`default_nettype none

module sync_length_xor_frame_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,

  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,

  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic [7:0]      echo_byte_o,
  output logic [8:0]      position_o,
  output logic            in_frame_o,
  output logic            frame_end_o,
  output logic            frame_ok_o,
  output logic            frame_abort_o,
  output logic [7:0]      command_o
);

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               out_valid_q;
  slxfp_pkg::result_t out_q;
  slxfp_pkg::result_t res_next;
  logic               advance;

  // word moves from input register to result register when the result slot frees
  assign advance    = in_valid_q && (!out_valid_q || res_ready_i);
  assign rx_ready_o = !in_valid_q || advance;

  slxfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_ready_o) begin
        in_valid_q <= rx_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      out_q <= res_next;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign echo_byte_o   = out_q.echo_byte;
  assign position_o    = out_q.position;
  assign in_frame_o    = out_q.in_frame;
  assign frame_end_o   = out_q.frame_end;
  assign frame_ok_o    = out_q.frame_ok;
  assign frame_abort_o = out_q.frame_abort;
  assign command_o     = out_q.command;

  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !res_ready_i |=> in_valid_q)
    else $error("buffered word lost while result stalled");

  a_fill_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("parsed word not presented");

  a_ready_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> rx_ready_o)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire
